// ----- src/awj_pkg.sv -----
// ----------------------------------------------------------------------------
// awj_pkg
// Shared types, codes and constants of the warp Jacobian / steepest-descent unit.
// ----------------------------------------------------------------------------
package awj_pkg;

    localparam int MAX_CHANNELS = 3;

    localparam logic [1:0] CMD_POINT  = 2'd0;
    localparam logic [1:0] CMD_GRAD   = 2'd1;
    localparam logic [1:0] CMD_COLUMN = 2'd2;

    localparam logic [17:0] W18_MAX = 18'h3ffff;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] slot0_x;
        logic signed [15:0] slot0_y;
        logic signed [15:0] slot1_x;
        logic signed [15:0] slot1_y;
        logic signed [15:0] slot2_x;
        logic signed [15:0] slot2_y;
        logic [1:0]         channel;
        logic               last_column;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [17:0]        weight_0;
        logic [17:0]        weight_1;
        logic [17:0]        weight_2;
        logic signed [31:0] jac_x;
        logic signed [31:0] jac_y;
        logic signed [47:0] sdi_0;
        logic signed [47:0] sdi_1;
        logic signed [47:0] sdi_2;
        logic               degenerate;
        logic               last_out;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       load;      // capture input item
        logic       num;       // compute numerators
        logic       div_start; // start divider on weight index div_idx
        logic [1:0] div_idx;
        logic       div_store; // store divider result
        logic       degen;     // latch degenerate flag
        logic       grad;      // write gradient
        logic       jac;       // jacobian products
        logic       jac_sum;   // jacobian sum and saturate
        logic       sdi_mul;   // sdi products
        logic       sdi_sum;   // sdi sum and saturate
        logic       emit_w;    // output weight result
        logic       emit_c;    // output column result
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic       div_busy;
        logic [1:0] command;
        logic       grad_ok;
    } sts_t;

endpackage

// ----- src/awj_if.sv -----
// ----------------------------------------------------------------------------
// awj_in_if / awj_out_if
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface awj_in_if;
    logic             valid;
    logic             ready;
    awj_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface awj_out_if;
    logic              valid;
    logic              ready;
    awj_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/awj_divider.sv -----
// ----------------------------------------------------------------------------
// awj_divider
// Restoring divider, 50-bit dividend / 34-bit divisor, one quotient bit per cycle;
// saturates the quotient to 18 bits.
// ----------------------------------------------------------------------------
module awj_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [49:0] dividend,
    input  logic [33:0] divisor,
    output logic        busy,
    output logic [17:0] quot
);
    logic [49:0] q_reg, q_next;
    logic [34:0] r_reg, r_next;
    logic [33:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [34:0] trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[33:0], q_reg[49]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 6'd50;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[34])
            begin
                r_next = trial;
                q_next = {q_reg[48:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[33:0], q_reg[49]};
                q_next = {q_reg[48:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = busy_reg;
    assign quot = (q_reg[49:18] != '0) ? awj_pkg::W18_MAX : q_reg[17:0];
endmodule

// ----- src/awj_datapath.sv -----
// ----------------------------------------------------------------------------
// awj_datapath
// Operand capture, numerators, weight/gradient storage, Jacobian and sdi math.
// ----------------------------------------------------------------------------
module awj_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  awj_pkg::in_item_t  in_data,
    input  logic [1:0]         channel_count,
    input  awj_pkg::ctl_t      ctl,
    output awj_pkg::sts_t      sts,
    output awj_pkg::out_item_t res
);
    awj_pkg::in_item_t it_reg;
    logic signed [33:0] n_reg [3];
    logic signed [33:0] d_reg;
    logic [17:0] w_reg [3];
    logic signed [15:0] gx_reg [3];
    logic signed [15:0] gy_reg [3];
    logic degen_reg;
    logic signed [34:0] px_reg [3];
    logic signed [34:0] py_reg [3];
    logic signed [31:0] jx_reg, jy_reg;
    logic signed [47:0] ax_reg [3];
    logic signed [47:0] ay_reg [3];
    logic signed [47:0] sdi_reg [3];

    logic signed [16:0] x, y, x1, y1, x2, y2, x3, y3;
    logic signed [33:0] n0, n1, n2;
    logic        div_start, div_busy;
    logic [49:0] dvd;
    logic [33:0] dvs;
    logic [17:0] quot;
    logic [1:0]  nch;
    logic signed [36:0] sx, sy;
    logic signed [33:0] rx, ry;
    logic signed [31:0] jx, jy;
    logic signed [48:0] ss [3];
    logic signed [33:0] nsel;
    logic        zero_w [3];

    assign x  = 17'(it_reg.pos_x);
    assign y  = 17'(it_reg.pos_y);
    assign x1 = 17'(it_reg.slot0_x);
    assign y1 = 17'(it_reg.slot0_y);
    assign x2 = 17'(it_reg.slot1_x);
    assign y2 = 17'(it_reg.slot1_y);
    assign x3 = 17'(it_reg.slot2_x);
    assign y3 = 17'(it_reg.slot2_y);

    // cofactor form: (x-xj)(y-yk) style cross products
    assign n0 = 34'((x2 - x) * (y3 - y)) - 34'((x3 - x) * (y2 - y));
    assign n1 = 34'((x3 - x) * (y1 - y)) - 34'((x1 - x) * (y3 - y));
    assign n2 = 34'((x1 - x) * (y2 - y)) - 34'((x2 - x) * (y1 - y));

    assign nsel = n_reg[ctl.div_idx];
    assign dvd = {(nsel[33] ? 34'(-nsel) : nsel), 16'd0};
    assign dvs = d_reg[33] ? 34'(-d_reg) : d_reg;
    assign div_start = ctl.div_start;

    awj_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .quot     (quot)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            zero_w[i] = (n_reg[i] == '0) || (d_reg == '0) || (n_reg[i][33] != d_reg[33]);
    end

    assign sx = 37'(px_reg[0]) + 37'(px_reg[1]) + 37'(px_reg[2]);
    assign sy = 37'(py_reg[0]) + 37'(py_reg[1]) + 37'(py_reg[2]);
    assign rx = 34'(sx >>> 3);
    assign ry = 34'(sy >>> 3);
    assign jx = (rx > 34'sd2147483647) ? 32'sh7fffffff :
                (rx < -34'sd2147483648) ? 32'sh80000000 : rx[31:0];
    assign jy = (ry > 34'sd2147483647) ? 32'sh7fffffff :
                (ry < -34'sd2147483648) ? 32'sh80000000 : ry[31:0];

    assign nch = (channel_count == 2'd0) ? 2'd1 :
                 (channel_count > 2'(awj_pkg::MAX_CHANNELS)) ? 2'(awj_pkg::MAX_CHANNELS)
                 : channel_count;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            ss[k] = 49'(ax_reg[k]) + 49'(ay_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degen_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                w_reg[i]  <= '0;
                gx_reg[i] <= '0;
                gy_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.degen)
                degen_reg <= (d_reg == '0);
            if (ctl.div_store)
                w_reg[ctl.div_idx] <= zero_w[ctl.div_idx] ? 18'd0 : quot;
            if (ctl.grad && it_reg.channel < 2'(awj_pkg::MAX_CHANNELS))
            begin
                gx_reg[it_reg.channel] <= it_reg.slot0_x;
                gy_reg[it_reg.channel] <= it_reg.slot0_y;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            it_reg <= in_data;
        if (ctl.num)
        begin
            n_reg[0] <= n0;
            n_reg[1] <= n1;
            n_reg[2] <= n2;
            d_reg    <= n0 + n1 + n2;
        end
        if (ctl.jac)
        begin
            px_reg[0] <= 35'($signed({1'b0, w_reg[0]}) * it_reg.slot0_x);
            px_reg[1] <= 35'($signed({1'b0, w_reg[1]}) * it_reg.slot1_x);
            px_reg[2] <= 35'($signed({1'b0, w_reg[2]}) * it_reg.slot2_x);
            py_reg[0] <= 35'($signed({1'b0, w_reg[0]}) * it_reg.slot0_y);
            py_reg[1] <= 35'($signed({1'b0, w_reg[1]}) * it_reg.slot1_y);
            py_reg[2] <= 35'($signed({1'b0, w_reg[2]}) * it_reg.slot2_y);
        end
        if (ctl.jac_sum)
        begin
            jx_reg <= jx;
            jy_reg <= jy;
        end
        if (ctl.sdi_mul)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ax_reg[k] <= 48'(gx_reg[k] * jx_reg);
                ay_reg[k] <= 48'(gy_reg[k] * jy_reg);
            end
        end
        if (ctl.sdi_sum)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) >= nch)
                    sdi_reg[k] <= '0;
                else if (ss[k][48] != ss[k][47])
                    sdi_reg[k] <= ss[k][48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
                else
                    sdi_reg[k] <= ss[k][47:0];
            end
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.command  = it_reg.command;
    assign sts.grad_ok  = 1'b1;

    always_comb
    begin
        res            = '0;
        res.kind       = ctl.emit_c;
        res.weight_0   = w_reg[0];
        res.weight_1   = w_reg[1];
        res.weight_2   = w_reg[2];
        res.degenerate = degen_reg;
        if (ctl.emit_c)
        begin
            res.jac_x    = jx_reg;
            res.jac_y    = jy_reg;
            res.sdi_0    = sdi_reg[0];
            res.sdi_1    = sdi_reg[1];
            res.sdi_2    = sdi_reg[2];
            res.last_out = it_reg.last_column;
        end
    end
endmodule

// ----- src/awj_ctrl.sv -----
// ----------------------------------------------------------------------------
// awj_ctrl
// Sequencer: accept, store a gradient or run the weight or column steps, hold result for output.
// ----------------------------------------------------------------------------
module awj_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  awj_pkg::sts_t sts,
    output awj_pkg::ctl_t ctl
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_NUM    = 4'd2;
    localparam logic [3:0] S_DSTART = 4'd3;
    localparam logic [3:0] S_DWAIT  = 4'd4;
    localparam logic [3:0] S_JAC    = 4'd5;
    localparam logic [3:0] S_JSUM   = 4'd6;
    localparam logic [3:0] S_SMUL   = 4'd7;
    localparam logic [3:0] S_SSUM   = 4'd8;
    localparam logic [3:0] S_OUTW   = 4'd9;
    localparam logic [3:0] S_OUTC   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        ctl.div_idx = idx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                ctl.load = in_valid;
                if (in_valid)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                unique case (sts.command)
                    awj_pkg::CMD_POINT:  state_next = S_NUM;
                    awj_pkg::CMD_COLUMN: state_next = S_JAC;
                    awj_pkg::CMD_GRAD:
                    begin
                        ctl.grad   = 1'b1;
                        state_next = S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
                idx_next = 2'd0;
            end
            S_NUM:
            begin
                ctl.num    = 1'b1;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                ctl.div_start = 1'b1;
                ctl.degen     = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!sts.div_busy)
                begin
                    ctl.div_store = 1'b1;
                    if (idx_reg == 2'd2)
                        state_next = S_OUTW;
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_DSTART;
                    end
                end
            end
            S_JAC:
            begin
                ctl.jac    = 1'b1;
                state_next = S_JSUM;
            end
            S_JSUM:
            begin
                ctl.jac_sum = 1'b1;
                state_next  = S_SMUL;
            end
            S_SMUL:
            begin
                ctl.sdi_mul = 1'b1;
                state_next  = S_SSUM;
            end
            S_SSUM:
            begin
                ctl.sdi_sum = 1'b1;
                state_next  = S_OUTC;
            end
            S_OUTW:
            begin
                ctl.emit_w = 1'b1;
                out_valid  = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            S_OUTC:
            begin
                ctl.emit_c = 1'b1;
                out_valid  = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule

// ----- src/aam_warp_jacobian_sdi_unit.sv -----
// ----------------------------------------------------------------------------
// aam_warp_jacobian_sdi_unit
// Barycentric weights, warp Jacobian and steepest-descent values per pixel.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  in_ch     in    valid/ready        command, position, slots, channel, last
//  out_ch    out   valid/ready        kind, weights, jacobian, sdi, flags
//  apb       in    psel/penable/...   channel_count at address 0
//
// One transaction at a time. A gradient load only stores, a column runs its
// products and sums, a point three 50-step divisions on the shared divider.
// The result is held registered until taken; stalls on out_ch hold the block.
// Reset (rst_n, async low) clears weights, gradients, flag; channel_count = 1.
module aam_warp_jacobian_sdi_unit
(
    input  logic        clk,
    input  logic        rst_n,
    awj_in_if.sink      in_ch,
    awj_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    awj_pkg::ctl_t ctl;
    awj_pkg::sts_t sts;
    logic [1:0] channel_count_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {30'd0, channel_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            channel_count_reg <= 2'd1;
        else if (psel && penable && pwrite && paddr == 2'd0)
            channel_count_reg <= pwdata[1:0];
    end

    awj_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    awj_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_data       (in_ch.data),
        .channel_count (channel_count_reg),
        .ctl           (ctl),
        .sts           (sts),
        .res           (out_ch.data)
    );
endmodule

// ----- tb/sv/tb_aam_warp_jacobian_sdi_unit.sv -----
// ----------------------------------------------------------------------------
// tb_aam_warp_jacobian_sdi_unit
// Self-checking bench: directed table, then random pixel sequences (gradient
// loads, point, parameter columns) checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_aam_warp_jacobian_sdi_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINT_LAT = 300;    // padded wait for a pending point

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    awj_in_if  in_ch ();
    awj_out_if out_ch ();

    aam_warp_jacobian_sdi_unit uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirror of the block's stores and register
    // ------------------------------------------------------------------
    logic [17:0]        wt_mirror [3];
    logic signed [15:0] gx_mirror [3];
    logic signed [15:0] gy_mirror [3];
    logic               degen_mirror;
    logic [1:0]         chan_count_mirror;

    awj_pkg::out_item_t expected_results [$];
    int        mismatches;
    int        idle_mode;       // 0: sender 7% / receiver 52%, 1: swapped, 2: none
    int        rx_hold;         // long receiver hold-off, in cycles

    // barycentric weight: |n| * 2^16 / |d|, zero when not same sign, saturated
    function automatic logic [17:0] bary_weight(longint n, longint d);
        longint unsigned an;
        longint unsigned ad;
        longint unsigned q;
        if (n == 0 || d == 0)
            return '0;
        if ((n < 0) != (d < 0))
            return '0;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = (an << 16) / ad;
        return (q > 262143) ? awj_pkg::W18_MAX : q[17:0];
    endfunction

    // weight-eigen dot product, floor shift by 3, saturated to 32 bits
    function automatic longint jacobian_entry(longint e0, longint e1, longint e2);
        longint s;
        s = longint'(wt_mirror[0]) * e0 + longint'(wt_mirror[1]) * e1
          + longint'(wt_mirror[2]) * e2;
        s = s >>> 3;
        if (s > 64'sd2147483647)
            s = 64'sd2147483647;
        if (s < -64'sd2147483648)
            s = -64'sd2147483648;
        return s;
    endfunction

    // updates the mirror and returns whether the transaction yields a result
    function automatic bit predict_result(awj_pkg::in_item_t it,
                                          output awj_pkg::out_item_t r);
        longint x, y, x1, y1, x2, y2, x3, y3;
        longint n0, n1, n2, d, jx, jy, s;
        int     nch;
        r = '0;
        case (it.command)
            awj_pkg::CMD_POINT:
            begin
                x  = $signed(it.pos_x);   y  = $signed(it.pos_y);
                x1 = $signed(it.slot0_x); y1 = $signed(it.slot0_y);
                x2 = $signed(it.slot1_x); y2 = $signed(it.slot1_y);
                x3 = $signed(it.slot2_x); y3 = $signed(it.slot2_y);
                n0 = y*x3 - y3*x + x*y2 - x2*y + x2*y3 - x3*y2;
                n1 = -y*x3 + x1*y + x3*y1 + y3*x - x1*y3 - x*y1;
                n2 = -x*y2 + x*y1 + x1*y2 + x2*y - x2*y1 - x1*y;
                d  = n0 + n1 + n2;
                degen_mirror = (d == 0);
                wt_mirror[0] = bary_weight(n0, d);
                wt_mirror[1] = bary_weight(n1, d);
                wt_mirror[2] = bary_weight(n2, d);
                r.kind       = 1'b0;
                r.weight_0   = wt_mirror[0];
                r.weight_1   = wt_mirror[1];
                r.weight_2   = wt_mirror[2];
                r.degenerate = degen_mirror;
                return 1'b1;
            end
            awj_pkg::CMD_GRAD:
            begin
                if (it.channel < awj_pkg::MAX_CHANNELS)
                begin
                    gx_mirror[it.channel] = it.slot0_x;
                    gy_mirror[it.channel] = it.slot0_y;
                end
                return 1'b0;
            end
            awj_pkg::CMD_COLUMN:
            begin
                jx  = jacobian_entry($signed(it.slot0_x), $signed(it.slot1_x),
                                     $signed(it.slot2_x));
                jy  = jacobian_entry($signed(it.slot0_y), $signed(it.slot1_y),
                                     $signed(it.slot2_y));
                nch = (chan_count_mirror == 0) ? 1 : int'(chan_count_mirror);
                if (nch > awj_pkg::MAX_CHANNELS)
                    nch = awj_pkg::MAX_CHANNELS;
                r.kind     = 1'b1;
                r.weight_0 = wt_mirror[0];
                r.weight_1 = wt_mirror[1];
                r.weight_2 = wt_mirror[2];
                r.jac_x    = jx[31:0];
                r.jac_y    = jy[31:0];
                for (int k = 0; k < nch; k++)
                begin
                    s = longint'(gx_mirror[k]) * jx + longint'(gy_mirror[k]) * jy;
                    if (s > 64'sd140737488355327)
                        s = 64'sd140737488355327;
                    if (s < -64'sd140737488355328)
                        s = -64'sd140737488355328;
                    case (k)
                        0: r.sdi_0 = s[47:0];
                        1: r.sdi_1 = s[47:0];
                        default: r.sdi_2 = s[47:0];
                    endcase
                end
                r.degenerate = degen_mirror;
                r.last_out   = it.last_column;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic awj_pkg::in_item_t mk_item(logic [1:0] cmd, int px, int py,
                                                  int a, int b, int c, int e, int f,
                                                  int g, logic [1:0] ch, logic last);
        awj_pkg::in_item_t it;
        it.command = cmd;
        it.pos_x = px[15:0]; it.pos_y = py[15:0];
        it.slot0_x = a[15:0]; it.slot0_y = b[15:0];
        it.slot1_x = c[15:0]; it.slot1_y = e[15:0];
        it.slot2_x = f[15:0]; it.slot2_y = g[15:0];
        it.channel = ch;
        it.last_column = last;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #15ms;
        $display("tb_aam_warp_jacobian_sdi_unit: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: random ready, optional long hold-off, field compare
    // ------------------------------------------------------------------
    task automatic report(string name, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", name, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction");
                end
                else
                begin
                    automatic awj_pkg::out_item_t w = expected_results.pop_front();
                    automatic awj_pkg::out_item_t g = out_ch.data;
                    if (w.kind !== g.kind)             report("kind", w.kind, g.kind);
                    if (w.weight_0 !== g.weight_0)     report("weight_0", w.weight_0, g.weight_0);
                    if (w.weight_1 !== g.weight_1)     report("weight_1", w.weight_1, g.weight_1);
                    if (w.weight_2 !== g.weight_2)     report("weight_2", w.weight_2, g.weight_2);
                    if (w.jac_x !== g.jac_x)           report("jac_x", w.jac_x, g.jac_x);
                    if (w.jac_y !== g.jac_y)           report("jac_y", w.jac_y, g.jac_y);
                    if (w.sdi_0 !== g.sdi_0)           report("sdi_0", w.sdi_0, g.sdi_0);
                    if (w.sdi_1 !== g.sdi_1)           report("sdi_1", w.sdi_1, g.sdi_1);
                    if (w.sdi_2 !== g.sdi_2)           report("sdi_2", w.sdi_2, g.sdi_2);
                    if (w.degenerate !== g.degenerate) report("degenerate", w.degenerate,
                                                              g.degenerate);
                    if (w.last_out !== g.last_out)     report("last_out", w.last_out,
                                                              g.last_out);
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold      <= rx_hold - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (idle_mode)
                    0:       out_ch.ready <= ($urandom_range(99) >= 52);
                    1:       out_ch.ready <= ($urandom_range(99) >= 7);
                    default: out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // one transaction on in_ch; expectation queued at acceptance
    task automatic send_item(awj_pkg::in_item_t it, bit typed, awj_pkg::out_item_t want);
        awj_pkg::out_item_t r;
        bit        has;
        int        gap_pct;
        gap_pct = (idle_mode == 0) ? 7 : (idle_mode == 1) ? 52 : 0;
        if ($urandom_range(99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        has = predict_result(it, r);
        if (has)
            expected_results.push_back(typed ? want : r);
    endtask

    // register write while idle: setup then access phase
    task automatic write_channel_count(logic [1:0] value);
        in_ch.valid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 2'd0;
        pwdata  <= {30'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        chan_count_mirror = value;
    endtask

    // pause until every result is back, then let a point finish if pending
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (POINT_LAT) @(posedge clk);
    endtask

    // small random triangle around a random center; sometimes full range
    function automatic awj_pkg::in_item_t random_point();
        int cx, cy;
        if ($urandom_range(9) == 0)
            return mk_item(awj_pkg::CMD_POINT, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom,
                           2'($urandom), 1'($urandom));
        cx = $urandom_range(0, 60000) - 30000;
        cy = $urandom_range(0, 60000) - 30000;
        return mk_item(awj_pkg::CMD_POINT,
                       cx + $urandom_range(0, 400) - 200, cy + $urandom_range(0, 400) - 200,
                       cx + $urandom_range(0, 600) - 300, cy + $urandom_range(0, 600) - 300,
                       cx + $urandom_range(0, 600) - 300, cy + $urandom_range(0, 600) - 300,
                       cx + $urandom_range(0, 600) - 300, cy + $urandom_range(0, 600) - 300,
                       2'($urandom), 1'($urandom));
    endfunction

    typedef struct {
        awj_pkg::in_item_t  it;
        bit                 typed;
        awj_pkg::out_item_t want;
    } stim_row_t;

    stim_row_t directed [$];

    initial
    begin
        automatic awj_pkg::out_item_t w;
        automatic int        sent;
        automatic int        nc;
        automatic logic [1:0] counts [6] = '{2'd1, 2'd3, 2'd0, 2'd2, 2'd3, 2'd1};

        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        idle_mode = 0;
        rx_hold = 0;
        mismatches = 0;
        for (int i = 0; i < 3; i++)
        begin
            wt_mirror[i] = '0; gx_mirror[i] = '0; gy_mirror[i] = '0;
        end
        degen_mirror = 1'b0;
        chan_count_mirror = 2'd1;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset all stores are zero: column result is all zero
        w = '0; w.kind = 1'b1; w.last_out = 1'b1;
        directed.push_back('{mk_item(awj_pkg::CMD_COLUMN, 0, 0, 32767, -32768, 32767,
                                     -32768, 32767, -32768, 0, 1), 1'b1, w});
        // all vertices coincide: zero determinant
        w = '0; w.degenerate = 1'b1;
        directed.push_back('{mk_item(awj_pkg::CMD_POINT, 5, 5, 7, 7, 7, 7, 7, 7, 0, 0),
                             1'b1, w});
        w = '0; w.kind = 1'b1; w.degenerate = 1'b1;
        directed.push_back('{mk_item(awj_pkg::CMD_COLUMN, 0, 0, 100, 100, 100, 100, 100,
                                     100, 0, 0), 1'b1, w});
        w = '0;
        // gradients at the extremes; out-of-range channel ignored
        directed.push_back('{mk_item(awj_pkg::CMD_GRAD, 0, 0, -32768, -32768, 0, 0, 0, 0,
                                     0, 0), 1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_GRAD, 0, 0, 32767, 32767, 0, 0, 0, 0,
                                     1, 0), 1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_GRAD, 0, 0, 32767, -32768, 0, 0, 0, 0,
                                     2, 0), 1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_GRAD, 0, 0, 1, 1, 0, 0, 0, 0, 3, 0),
                             1'b0, w});
        // unknown command: nothing
        directed.push_back('{mk_item(2'd3, -1, -1, -1, -1, -1, -1, -1, -1, 3, 1), 1'b0, w});
        // pixel on a vertex: one full weight
        directed.push_back('{mk_item(awj_pkg::CMD_POINT, 0, 0, 0, 0, 16, 0, 0, 16, 0, 0),
                             1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_COLUMN, 0, 0, 32767, 32767, -32768,
                                     -32768, 1, -1, 0, 1), 1'b0, w});
        // pixel far outside a tiny triangle: zero and saturated weights
        directed.push_back('{mk_item(awj_pkg::CMD_POINT, 32767, -32768, 0, 0, 1, 0, 0, 1,
                                     0, 0), 1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_COLUMN, 0, 0, 32767, -32768, 32767,
                                     -32768, 32767, -32768, 0, 0), 1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_COLUMN, 0, 0, -32768, 32767, -32768,
                                     32767, -32768, 32767, 0, 1), 1'b0, w});
        // extreme coordinates everywhere
        directed.push_back('{mk_item(awj_pkg::CMD_POINT, -32768, 32767, 32767, -32768,
                                     -32768, -32768, 32767, 32767, 0, 0), 1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_POINT, 0, 0, -32768, -32768, 32767,
                                     -32768, 0, 32767, 0, 0), 1'b0, w});
        directed.push_back('{mk_item(awj_pkg::CMD_COLUMN, 0, 0, 32767, 32767, 32767,
                                     32767, 32767, 32767, 0, 1), 1'b0, w});

        foreach (directed[i])
            send_item(directed[i].it, directed[i].typed, directed[i].want);
        drain();

        // long receiver hold-off while items keep coming
        rx_hold = 500;
        sent = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            idle_mode = phase / 2;
            write_channel_count(counts[phase]);
            while (sent < (phase + 1) * 190)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // noise: anything at all
                    send_item(mk_item(2'($urandom), $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom,
                                      $urandom, 2'($urandom), 1'($urandom)), 1'b0, w);
                    sent++;
                end
                else
                begin
                    // one pixel: gradient loads, point, parameter columns
                    repeat ($urandom_range(0, 3))
                    begin
                        send_item(mk_item(awj_pkg::CMD_GRAD, $urandom, $urandom,
                                          $urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, 2'($urandom_range(0, 2)),
                                          1'($urandom)), 1'b0, w);
                        sent++;
                    end
                    send_item(random_point(), 1'b0, w);
                    sent++;
                    nc = $urandom_range(1, 6);
                    for (int c = 0; c < nc; c++)
                    begin
                        send_item(mk_item(awj_pkg::CMD_COLUMN, $urandom, $urandom,
                                          $urandom, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, 2'($urandom), c == nc - 1),
                                  1'b0, w);
                        sent++;
                    end
                end
            end
            drain();
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_aam_warp_jacobian_sdi_unit: done, clean");
        else
            $display("tb_aam_warp_jacobian_sdi_unit: done, errors");
        $finish;
    end
endmodule

// ----- sim.f -----
src/awj_pkg.sv
src/awj_if.sv
src/awj_divider.sv
src/awj_datapath.sv
src/awj_ctrl.sv
src/aam_warp_jacobian_sdi_unit.sv
tb/sv/tb_aam_warp_jacobian_sdi_unit.sv
